/* rtl/pnfe_pkg.sv */
// pnfe_pkg: shared constants, codes and interface types of the petri net firing engine
`timescale 1ns / 1ps

package pnfe_pkg;

	// architectural limits fixed by the port widths
	localparam int MAX_PLACES      = 8;
	localparam int MAX_TRANSITIONS = 8;
	localparam int MAX_TOKEN_WIDTH = 8;

	// default sizes
	localparam int DEF_PLACES      = 8;
	localparam int DEF_TRANSITIONS = 8;
	localparam int DEF_TOKEN_WIDTH = 8;

	localparam int ARC_MAP_WIDTH   = 64;
	localparam int MARKING_WIDTH   = 64;
	localparam int COUNT_WIDTH     = 4;
	localparam int REG_INDEX_WIDTH = 2;

	// opcodes
	localparam logic [1:0] OP_FIRE  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_ENABLED = 2'd1;
	localparam logic [1:0] ST_NOT_IN_USE  = 2'd2;

	// register indexes
	localparam logic [REG_INDEX_WIDTH-1:0] REG_INPUT_ARCS  = 2'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_OUTPUT_ARCS = 2'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_TRANS_USED  = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] TRANS_USED_RESET = 4'd8;

	// commands from the controller to the datapath
	typedef struct packed {
		logic execute;
		logic report;
	} pnfe_cmd_t;

endpackage

/* rtl/pnfe_ctrl.sv */
// pnfe_ctrl: controller state machine sequencing execute and report
`timescale 1ns / 1ps

module pnfe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output pnfe_pkg::pnfe_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.execute = start && (state_q == S_IDLE);
	assign cmd.report  = (state_q == S_REPORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_exec_then_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> cmd.report)
		else $error("execute not followed by report");

	a_report_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> done_q)
		else $error("report not followed by done strobe");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done strobe held longer than one cycle");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.execute && cmd.report))
		else $error("execute and report issued together");

endmodule

/* rtl/pnfe_datapath.sv */
// pnfe_datapath: marking store, arc registers, enable logic and result registers
`timescale 1ns / 1ps

module pnfe_datapath #(
	parameter int PLACES      = pnfe_pkg::DEF_PLACES,
	parameter int TRANSITIONS = pnfe_pkg::DEF_TRANSITIONS,
	parameter int TOKEN_WIDTH = pnfe_pkg::DEF_TOKEN_WIDTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pnfe_pkg::pnfe_cmd_t                       cmd,
	input  logic                                      wr_en,
	input  logic [pnfe_pkg::REG_INDEX_WIDTH-1:0]      wr_index,
	input  logic [pnfe_pkg::ARC_MAP_WIDTH-1:0]        wr_data,
	input  logic [1:0]                                opcode,
	input  logic [2:0]                                transition_index,
	input  logic [2:0]                                place_index,
	input  logic [7:0]                                token_value,
	output logic [1:0]                                status,
	output logic [7:0]                                enabled_mask,
	output logic                                      deadlock,
	output logic [pnfe_pkg::MARKING_WIDTH-1:0]        marking
);

	localparam int MT = pnfe_pkg::MAX_TRANSITIONS;
	localparam logic [TOKEN_WIDTH-1:0] TOKEN_MAX   = '1;
	localparam logic [7:0]             TOKEN_MAX_W = 8'((1 << TOKEN_WIDTH) - 1);

	logic [TOKEN_WIDTH-1:0] tokens_q [PLACES];
	logic [pnfe_pkg::ARC_MAP_WIDTH-1:0] in_arcs_q;
	logic [pnfe_pkg::ARC_MAP_WIDTH-1:0] out_arcs_q;
	logic [pnfe_pkg::COUNT_WIDTH-1:0]   trans_used_q;

	logic [1:0]                         exec_status_q;
	logic [1:0]                         res_status_q;
	logic [7:0]                         res_mask_q;
	logic                               res_deadlock_q;
	logic [pnfe_pkg::MARKING_WIDTH-1:0] res_marking_q;

	logic [pnfe_pkg::COUNT_WIDTH-1:0]   n_eff;
	logic [PLACES-1:0]                  nonzero;
	logic [MT-1:0]                      en_all;
	logic [MT-1:0]                      mask;
	logic [PLACES-1:0]                  sel_ins;
	logic [PLACES-1:0]                  sel_outs;
	logic                               sel_en;
	logic                               sel_in_use;
	logic [TOKEN_WIDTH-1:0]             fire_next [PLACES];
	logic [TOKEN_WIDTH-1:0]             load_val;
	logic [1:0]                         fire_status;
	logic [pnfe_pkg::MARKING_WIDTH-1:0] marking_now;

	// register value above the build size counts as the build size
	assign n_eff = (trans_used_q > pnfe_pkg::COUNT_WIDTH'(TRANSITIONS))
		? pnfe_pkg::COUNT_WIDTH'(TRANSITIONS) : trans_used_q;

	assign load_val = (token_value > TOKEN_MAX_W) ? TOKEN_MAX
		: token_value[TOKEN_WIDTH-1:0];

	always_comb begin
		for (int p = 0; p < PLACES; p++) begin
			nonzero[p] = (tokens_q[p] != '0);
		end
		for (int t = 0; t < MT; t++) begin
			en_all[t] = &(~in_arcs_q[8*t +: PLACES] | nonzero);
			mask[t]   = en_all[t] && (pnfe_pkg::COUNT_WIDTH'(t) < n_eff);
		end
	end

	// arcs and enable of the addressed transition
	always_comb begin
		sel_ins    = '0;
		sel_outs   = '0;
		sel_en     = 1'b0;
		sel_in_use = 1'b0;
		for (int t = 0; t < MT; t++) begin
			if (transition_index == 3'(t)) begin
				sel_ins    = in_arcs_q[8*t +: PLACES];
				sel_outs   = out_arcs_q[8*t +: PLACES];
				sel_en     = en_all[t];
				sel_in_use = (pnfe_pkg::COUNT_WIDTH'(t) < n_eff);
			end
		end
	end

	// consume then produce, saturating
	always_comb begin
		for (int p = 0; p < PLACES; p++) begin
			fire_next[p] = tokens_q[p] - TOKEN_WIDTH'(sel_ins[p]);
			if (sel_outs[p] && (fire_next[p] != TOKEN_MAX)) begin
				fire_next[p] = fire_next[p] + TOKEN_WIDTH'(1);
			end
		end
	end

	always_comb begin
		if (!sel_in_use) begin
			fire_status = pnfe_pkg::ST_NOT_IN_USE;
		end else if (!sel_en) begin
			fire_status = pnfe_pkg::ST_NOT_ENABLED;
		end else begin
			fire_status = pnfe_pkg::ST_OK;
		end
	end

	always_comb begin
		marking_now = '0;
		for (int p = 0; p < PLACES; p++) begin
			marking_now[8*p +: 8] = 8'(tokens_q[p]);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arcs_q    <= '0;
			out_arcs_q   <= '0;
			trans_used_q <= pnfe_pkg::TRANS_USED_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				pnfe_pkg::REG_INPUT_ARCS:  in_arcs_q    <= wr_data;
				pnfe_pkg::REG_OUTPUT_ARCS: out_arcs_q   <= wr_data;
				pnfe_pkg::REG_TRANS_USED:  trans_used_q <= wr_data[pnfe_pkg::COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// marking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLACES; p++) begin
				tokens_q[p] <= '0;
			end
		end else if (cmd.execute) begin
			case (opcode)
				pnfe_pkg::OP_FIRE: begin
					if (fire_status == pnfe_pkg::ST_OK) begin
						for (int p = 0; p < PLACES; p++) begin
							tokens_q[p] <= fire_next[p];
						end
					end
				end
				pnfe_pkg::OP_LOAD: begin
					for (int p = 0; p < PLACES; p++) begin
						if (place_index == 3'(p)) begin
							tokens_q[p] <= load_val;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// status of the step and result registers
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			exec_status_q <= (opcode == pnfe_pkg::OP_FIRE) ? fire_status : pnfe_pkg::ST_OK;
		end
		if (cmd.report) begin
			res_status_q   <= exec_status_q;
			res_mask_q     <= 8'(mask);
			res_deadlock_q <= (mask == '0);
			res_marking_q  <= marking_now;
		end
	end

	assign status       = res_status_q;
	assign enabled_mask = res_mask_q;
	assign deadlock     = res_deadlock_q;
	assign marking      = res_marking_q;

endmodule

/* rtl/petri_net_firing_engine.sv */
// petri_net_firing_engine: top level of the petri net token game engine
`timescale 1ns / 1ps
//
// usage
// - configuration: wr_en, wr_index, wr_data write one register per cycle while idle;
//   index 0 input arc map, 1 output arc map, 2 transitions in use (bits 3:0)
// - command: a transfer is taken at a rising edge with start high and busy low;
//   opcode selects fire, load of one place count, or query
// - result: status, enabled_mask, deadlock and marking stand for exactly one cycle
//   with done high; the receiver cannot stall, so the result must be taken then
// - sequence: the command edge executes the step on the marking; the report state
//   then evaluates enables and registers the result with the done strobe
// - commands: a new command is taken only when idle, after the report state of the
//   previous one, as set by the execute then report sequence of the controller;
//   busy is high for the report cycle
// - reset: arst_n clears the marking, the arc maps and sets transitions in use to 8;
//   no clearing pass, a command may follow at once
//
module petri_net_firing_engine #(
	parameter int PLACES      = pnfe_pkg::DEF_PLACES,
	parameter int TRANSITIONS = pnfe_pkg::DEF_TRANSITIONS,
	parameter int TOKEN_WIDTH = pnfe_pkg::DEF_TOKEN_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 wr_en,
	input  logic [pnfe_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [pnfe_pkg::ARC_MAP_WIDTH-1:0]   wr_data,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           opcode,
	input  logic [2:0]                           transition_index,
	input  logic [2:0]                           place_index,
	input  logic [7:0]                           token_value,
	// result channel
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [7:0]                           enabled_mask,
	output logic                                 deadlock,
	output logic [pnfe_pkg::MARKING_WIDTH-1:0]   marking
);

	// command bundle from controller to datapath
	pnfe_pkg::pnfe_cmd_t cmd;

	// sequencing: idle, then the report state for each accepted command
	pnfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// marking, arc registers, enable logic and result registers
	pnfe_datapath #(
		.PLACES      (PLACES),
		.TRANSITIONS (TRANSITIONS),
		.TOKEN_WIDTH (TOKEN_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.opcode           (opcode),
		.transition_index (transition_index),
		.place_index      (place_index),
		.token_value      (token_value),
		.status           (status),
		.enabled_mask     (enabled_mask),
		.deadlock         (deadlock),
		.marking          (marking)
	);

endmodule

/* tb/testbench.sv */
// testbench: self-checking testbench of the petri net firing engine with its own token game predictor
`timescale 1ns / 1ps

module testbench;

	// opcode 3 has no name in the package, it acts as a query
	localparam logic [1:0] OP_SPARE = 2'd3;
	// register index 3 selects nothing and must leave every register alone
	localparam logic [pnfe_pkg::REG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

	localparam int RANDOM_PHASES    = 10;
	localparam int ITEMS_PER_PHASE  = 150;
	localparam int SETTLE_CYCLES    = 4;
	localparam int DRAIN_LIMIT      = 200;

	// one result transfer as the block reports it
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  enabled_mask;
		logic        deadlock;
		logic [63:0] marking;
	} step_result_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [63:0] wr_data;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [2:0]  transition_index;
	logic [2:0]  place_index;
	logic [7:0]  token_value;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  enabled_mask;
	logic        deadlock;
	logic [63:0] marking;

	// shadow of the net held by the predictor
	logic [63:0] input_arcs;
	logic [63:0] output_arcs;
	logic [3:0]  trans_used;
	logic [7:0]  place_count [8];

	step_result_t pending_results [$];
	int           fail_count;
	bit           steady_sender;

	petri_net_firing_engine dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.transition_index (transition_index),
		.place_index      (place_index),
		.token_value      (token_value),
		.done             (done),
		.status           (status),
		.enabled_mask     (enabled_mask),
		.deadlock         (deadlock),
		.marking          (marking)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// register values above the transition count saturate, zero means an empty net
	function automatic int live_transitions();
		return (trans_used > 4'd8) ? 8 : int'(trans_used);
	endfunction

	// enabled when no input place is empty; no input places at all means always enabled
	function automatic bit can_fire(int t);
		for (int p = 0; p < 8; p++) begin
			if (input_arcs[8*t+p] && place_count[p] == 8'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// one step of the token game: update the shadow marking and build the report
	function automatic step_result_t play_token_step(logic [1:0] op, logic [2:0] tix,
			logic [2:0] pix, logic [7:0] val);
		step_result_t r;
		int           live;
		logic [7:0]   ins;
		logic [7:0]   outs;
		r = '0;
		live = live_transitions();
		r.status = pnfe_pkg::ST_OK;
		if (op == pnfe_pkg::OP_FIRE) begin
			if (int'(tix) >= live) begin
				r.status = pnfe_pkg::ST_NOT_IN_USE;
			end else if (!can_fire(int'(tix))) begin
				r.status = pnfe_pkg::ST_NOT_ENABLED;
			end else begin
				ins  = input_arcs[8*tix +: 8];
				outs = output_arcs[8*tix +: 8];
				// take first, then give, so a self loop at the top stays saturated
				for (int p = 0; p < 8; p++) begin
					if (ins[p])
						place_count[p] = place_count[p] - 8'd1;
				end
				for (int p = 0; p < 8; p++) begin
					if (outs[p] && place_count[p] != 8'hFF)
						place_count[p] = place_count[p] + 8'd1;
				end
			end
		end else if (op == pnfe_pkg::OP_LOAD) begin
			place_count[pix] = val;
		end
		// query and the spare opcode change nothing
		for (int t = 0; t < live; t++) begin
			if (can_fire(t))
				r.enabled_mask[t] = 1'b1;
		end
		r.deadlock = (r.enabled_mask == 8'd0);
		for (int p = 0; p < 8; p++)
			r.marking[8*p +: 8] = place_count[p];
		return r;
	endfunction

	// append one prediction behind the ones still outstanding
	function automatic void record_prediction(step_result_t r);
		pending_results = {pending_results, r};
	endfunction

	// ------------------------------------------------------------------
	// result checker: every strobe must match the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (enabled_mask !== want.enabled_mask) begin
					$error("enabled_mask: expected %02h, actual %02h",
						want.enabled_mask, enabled_mask);
					fail_count++;
				end
				if (deadlock !== want.deadlock) begin
					$error("deadlock: expected %0b, actual %0b", want.deadlock, deadlock);
					fail_count++;
				end
				if (marking !== want.marking) begin
					$error("marking: expected %016h, actual %016h", want.marking, marking);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// shared driving tasks
	// ------------------------------------------------------------------

	// one command transfer; start stays high afterwards so a following command can go
	// back to back, and a random gap first drops it low
	task automatic send_step(logic [1:0] op, logic [2:0] tix, logic [2:0] pix,
			logic [7:0] val);
		int gap;
		gap = 0;
		if (!steady_sender && $urandom_range(0, 99) < 12)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start            <= 1'b1;
		opcode           <= op;
		transition_index <= tix;
		place_index      <= pix;
		token_value      <= val;
		// the transfer happens at the first edge with busy low
		@(posedge clk);
		while (busy) @(posedge clk);
		record_prediction(play_token_step(op, tix, pix, val));
	endtask

	// drop start and let every outstanding result come back, then a little slack
	task automatic settle_net();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic write_reg(logic [pnfe_pkg::REG_INDEX_WIDTH-1:0] idx, logic [63:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			pnfe_pkg::REG_INPUT_ARCS:  input_arcs  = data;
			pnfe_pkg::REG_OUTPUT_ARCS: output_arcs = data;
			pnfe_pkg::REG_TRANS_USED:  trans_used  = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// straight out of reset: empty arc maps make every transition enabled
	task automatic test_idle_net();
		send_step(pnfe_pkg::OP_QUERY, 3'd0, 3'd0, 8'd0);
		send_step(pnfe_pkg::OP_FIRE, 3'd7, 3'd7, 8'hFF);
		send_step(OP_SPARE, 3'd0, 3'd0, 8'd0);
	endtask

	// token flow through a small hand-built net: consumption, self loop, saturation
	task automatic test_token_moves();
		settle_net();
		// t0: p0,p1 -> p2   t1: p3 self loop   t2: source into p7
		// t3: p4 -> p5,p6   t4..t7: need every place, produce nothing
		write_reg(pnfe_pkg::REG_INPUT_ARCS,  64'hFFFF_FFFF_1000_0803);
		write_reg(pnfe_pkg::REG_OUTPUT_ARCS, 64'h0000_0000_6080_0804);
		write_reg(pnfe_pkg::REG_TRANS_USED,  64'd8);
		send_step(pnfe_pkg::OP_FIRE, 3'd0, 3'd0, 8'd0);     // inputs empty, not enabled
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd0, 8'd1);
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd1, 8'hFF);
		send_step(pnfe_pkg::OP_FIRE, 3'd0, 3'd0, 8'd0);     // p0 empties, p2 gains one
		send_step(pnfe_pkg::OP_FIRE, 3'd0, 3'd0, 8'd0);     // disabled again
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd3, 8'hFF);
		send_step(pnfe_pkg::OP_FIRE, 3'd1, 3'd0, 8'd0);     // self loop stays at the top
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd7, 8'hFF);
		send_step(pnfe_pkg::OP_FIRE, 3'd2, 3'd0, 8'd0);     // source into a full place
		send_step(pnfe_pkg::OP_FIRE, 3'd3, 3'd0, 8'd0);     // p4 empty
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd4, 8'd2);
		send_step(pnfe_pkg::OP_FIRE, 3'd3, 3'd0, 8'd0);
		send_step(pnfe_pkg::OP_LOAD, 3'd0, 3'd2, 8'd0);     // load of zero
		send_step(pnfe_pkg::OP_QUERY, 3'd5, 3'd5, 8'h55);
	endtask

	// transition count at zero, above range and at one; spare register index
	task automatic test_transition_count();
		settle_net();
		write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(pnfe_pkg::REG_TRANS_USED, 64'd0);
		send_step(pnfe_pkg::OP_FIRE, 3'd0, 3'd0, 8'd0);     // nothing exists, deadlock
		settle_net();
		write_reg(pnfe_pkg::REG_TRANS_USED, 64'hF);
		send_step(pnfe_pkg::OP_QUERY, 3'd0, 3'd0, 8'd0);
		send_step(pnfe_pkg::OP_FIRE, 3'd7, 3'd0, 8'd0);
		settle_net();
		write_reg(pnfe_pkg::REG_TRANS_USED, 64'd1);
		send_step(pnfe_pkg::OP_FIRE, 3'd1, 3'd0, 8'd0);     // index beyond the count
		send_step(pnfe_pkg::OP_FIRE, 3'd0, 3'd0, 8'd0);
	endtask

	// random nets with random command streams; small token values keep the
	// enables changing so fires both succeed and fail
	task automatic test_random_play();
		logic [63:0] in_map;
		logic [63:0] out_map;
		logic [3:0]  count;
		int          pick;
		logic [1:0]  op;
		logic [7:0]  val;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_net();
			if (phase == 0) begin
				in_map  = '1;
				out_map = '1;
				count   = 4'd8;
			end else if (phase == 1) begin
				in_map  = '0;
				out_map = '0;
				count   = 4'd1;
			end else begin
				for (int t = 0; t < 8; t++) begin
					in_map[8*t +: 8]  = 8'($urandom & $urandom & $urandom);
					out_map[8*t +: 8] = 8'($urandom & $urandom);
				end
				pick = $urandom_range(0, 9);
				if (pick == 0)
					count = 4'd0;
				else if (pick == 1)
					count = 4'($urandom_range(9, 15));
				else
					count = 4'($urandom_range(1, 8));
			end
			write_reg(pnfe_pkg::REG_INPUT_ARCS, in_map);
			write_reg(pnfe_pkg::REG_OUTPUT_ARCS, out_map);
			write_reg(pnfe_pkg::REG_TRANS_USED, {60'd0, count});
			// one phase runs with no sender gaps at all
			steady_sender = (phase == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					op = pnfe_pkg::OP_FIRE;
				else if (pick < 78)
					op = pnfe_pkg::OP_LOAD;
				else if (pick < 92)
					op = pnfe_pkg::OP_QUERY;
				else
					op = OP_SPARE;
				pick = $urandom_range(0, 9);
				if (pick < 5)
					val = 8'($urandom_range(0, 3));
				else if (pick < 7)
					val = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'hFE;
				else
					val = 8'($urandom);
				send_step(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), val);
			end
			steady_sender = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------

	initial begin
		int waited;
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		start            = 1'b0;
		opcode           = pnfe_pkg::OP_QUERY;
		transition_index = '0;
		place_index      = '0;
		token_value      = '0;
		fail_count       = 0;
		steady_sender    = 1'b0;
		// reset state of the shadow net
		input_arcs  = '0;
		output_arcs = '0;
		trans_used  = pnfe_pkg::TRANS_USED_RESET;
		for (int p = 0; p < 8; p++)
			place_count[p] = 8'd0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_net();
		test_token_moves();
		test_transition_count();
		test_random_play();

		// drain with a bound, then give any stray strobe time to show up
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() > 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
